// ===== hdl/fcal_pkg.sv =====
package fcal_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int WORD_BITS_DEFAULT = 32;
    localparam int CFG_W             = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0] {
        FN_APPEND     = 3'd0,
        FN_PREPEND    = 3'd1,
        FN_DROP_LAST  = 3'd2,
        FN_DROP_FIRST = 3'd3,
        FN_REMOVE_AT  = 3'd4,
        FN_READ_AT    = 3'd5,
        FN_CLEAR      = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD       = 2'd0,
        OP_LOAD       = 2'd1,
        OP_FROM_LEFT  = 2'd2,
        OP_FROM_RIGHT = 2'd3
    } cell_op_t;

endpackage

// ===== hdl/fcal_if.sv =====
interface fcal_req_if #(
    parameter int WORD_BITS = 32,
    parameter int POS_W     = 4
) ();
    logic                 valid;
    logic                 ready;
    logic [2:0]           func;
    logic [WORD_BITS-1:0] element_value;
    logic [POS_W-1:0]     position;

    modport source (output valid, output func, output element_value, output position,
                    input ready);
    modport sink   (input valid, input func, input element_value, input position,
                    output ready);
endinterface

interface fcal_rsp_if #(
    parameter int WORD_BITS = 32,
    parameter int CNT_W     = 5
) ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [WORD_BITS-1:0] read_value;
    logic [CNT_W-1:0]     length_after;

    modport source (output valid, output status, output read_value, output length_after,
                    input ready);
    modport sink   (input valid, input status, input read_value, input length_after,
                    output ready);
endinterface

interface fcal_cfg_if ();
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/fcal_cell.sv =====
module fcal_cell #(
    parameter int WORD_BITS = fcal_pkg::WORD_BITS_DEFAULT
) (
    input  logic                 clk,
    input  fcal_pkg::cell_op_t   op,
    input  logic [WORD_BITS-1:0] load_word,
    input  logic [WORD_BITS-1:0] left_word,
    input  logic [WORD_BITS-1:0] right_word,
    output logic [WORD_BITS-1:0] word
);
    import fcal_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    always_comb
    begin
        unique case (op)
            OP_LOAD:       word_next = load_word;
            OP_FROM_LEFT:  word_next = left_word;
            OP_FROM_RIGHT: word_next = right_word;
            default:       word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== hdl/fixed_capacity_array_list_top.sv =====
// Bounded ordered list of up to DEPTH words, held in a row of word cells that
// all shift into their neighbours together. Each request gives exactly one
// response; a request is taken in the cycle it is offered whenever the response
// register is empty or being emptied, so while responses are taken the block
// handles one request per cycle, each answered on the cycle after acceptance.
// The limit register may only be written while no request is outstanding.
module fixed_capacity_array_list_top #(
    parameter int DEPTH     = fcal_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = fcal_pkg::WORD_BITS_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    fcal_req_if.sink   req,
    fcal_rsp_if.source rsp,
    fcal_cfg_if.sink   cfg
);
    import fcal_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CFG_W-1:0]     cap_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    status_t              status_reg, status_next;
    logic [WORD_BITS-1:0] rdata_reg, rdata_next;
    logic [CNT_W-1:0]     len_reg;

    logic [WORD_BITS-1:0] entry [DEPTH];
    cell_op_t             cmd [DEPTH];

    logic             accept;
    logic             full, empty, range_bad;
    logic [CMP_W-1:0] count_x, cap_x, pos_x;

    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    assign count_x   = CMP_W'(count_reg);
    assign cap_x     = CMP_W'(cap_reg);
    assign pos_x     = CMP_W'(req.position);
    assign full      = (count_x >= cap_x) || (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign range_bad = (pos_x >= count_x);

    always_comb
    begin
        status_next = ST_OK;
        rdata_next  = '0;
        count_next  = count_reg;
        for (int k = 0; k < DEPTH; k++)
        begin
            cmd[k] = OP_HOLD;
        end
        unique case (req.func)
            FN_APPEND:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    for (int k = 0; k < DEPTH; k++)
                    begin
                        if (count_reg == CNT_W'(k))
                        begin
                            cmd[k] = OP_LOAD;
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_PREPEND:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    for (int k = 0; k < DEPTH; k++)
                    begin
                        cmd[k] = OP_FROM_LEFT;
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_DROP_LAST:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            FN_DROP_FIRST:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    for (int k = 0; k < DEPTH; k++)
                    begin
                        cmd[k] = OP_FROM_RIGHT;
                    end
                    count_next = count_reg - CNT_W'(1);
                end
            end
            FN_REMOVE_AT:
            begin
                if (range_bad)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    for (int k = 0; k < DEPTH; k++)
                    begin
                        if (CMP_W'(k) >= pos_x)
                        begin
                            cmd[k] = OP_FROM_RIGHT;
                        end
                    end
                    count_next = count_reg - CNT_W'(1);
                end
            end
            FN_READ_AT:
            begin
                if (range_bad)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    rdata_next = entry[req.position];
                end
            end
            FN_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_word;
        logic [WORD_BITS-1:0] right_word;

        if (g == 0)
        begin : g_first
            assign left_word = req.element_value;
        end
        else
        begin : g_mid_l
            assign left_word = entry[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_word = entry[g];
        end
        else
        begin : g_mid_r
            assign right_word = entry[g+1];
        end

        fcal_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk        (clk),
            .op         (accept ? cmd[g] : OP_HOLD),
            .load_word  (req.element_value),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (entry[g])
        );
    end

    assign rsp_valid_next = accept ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
            len_reg    <= count_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.read_value   = rdata_reg;
    assign rsp.length_after = len_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the depth.");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid && (rsp.length_after == count_reg))
        else $error("Accepted request gave no matching response.");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.func == FN_CLEAR) |=> (count_reg == '0))
        else $error("Clear did not empty the list.");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_OK) |-> (rsp.read_value == '0))
        else $error("Failed request returned read data.");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import fcal_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int WORD_BITS   = WORD_BITS_DEFAULT;
    localparam logic [2:0] FN_UNDEF = 3'd7;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASES      = 12;
    localparam int PHASE_REQS  = 150;
    localparam int DIR_ROWS    = 25;

    typedef struct packed {
        status_t              status;
        logic [WORD_BITS-1:0] read_value;
        logic [4:0]           length_after;
    } list_resp_t;

    typedef struct {
        bit                   is_cfg;
        logic [2:0]           func;
        logic [WORD_BITS-1:0] value;
        logic [3:0]           position;
        bit                   typed;
        list_resp_t           answer;
    } dir_row_t;

    logic clk;
    logic rst_n;

    fcal_req_if #(.WORD_BITS(WORD_BITS), .POS_W(4)) req_ch ();
    fcal_rsp_if #(.WORD_BITS(WORD_BITS), .CNT_W(5)) rsp_ch ();
    fcal_cfg_if                                     cfg_ch ();

    fixed_capacity_array_list_top #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    logic [WORD_BITS-1:0] shadow_words [DEPTH];
    int unsigned          shadow_len;
    logic [4:0]           shadow_cap;
    list_resp_t           pending_answers [$];

    bit no_idle;
    int fail_count;
    int stall_cycles;
    int requests_sent;
    int cap_writes;
    int answers_checked;
    int full_seen;
    int empty_seen;
    int range_seen;
    int longest_list;

    // Directed requests; rows with typed set carry their answer in full.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, FN_DROP_LAST,  32'h0,        4'd0,  1'b1, '{ST_EMPTY, 32'h0,        5'd0}},
        '{1'b0, FN_DROP_FIRST, 32'h0,        4'd0,  1'b1, '{ST_EMPTY, 32'h0,        5'd0}},
        '{1'b0, FN_READ_AT,    32'h0,        4'd0,  1'b1, '{ST_RANGE, 32'h0,        5'd0}},
        '{1'b0, FN_REMOVE_AT,  32'h0,        4'd15, 1'b1, '{ST_RANGE, 32'h0,        5'd0}},
        '{1'b0, FN_APPEND,     32'hFFFFFFFF, 4'd0,  1'b1, '{ST_OK,    32'h0,        5'd1}},
        '{1'b0, FN_PREPEND,    32'h0,        4'd15, 1'b1, '{ST_OK,    32'h0,        5'd2}},
        '{1'b0, FN_APPEND,     32'h5A5A5A5A, 4'd0,  1'b1, '{ST_OK,    32'h0,        5'd3}},
        '{1'b0, FN_READ_AT,    32'hFFFFFFFF, 4'd0,  1'b1, '{ST_OK,    32'h0,        5'd3}},
        '{1'b0, FN_READ_AT,    32'h0,        4'd1,  1'b1, '{ST_OK,    32'hFFFFFFFF, 5'd3}},
        '{1'b0, FN_READ_AT,    32'h0,        4'd3,  1'b1, '{ST_RANGE, 32'h0,        5'd3}},
        '{1'b0, FN_UNDEF,      32'hFFFFFFFF, 4'd15, 1'b1, '{ST_OK,    32'h0,        5'd3}},
        '{1'b0, FN_REMOVE_AT,  32'h0,        4'd1,  1'b0, '{ST_OK,    32'h0,        5'd0}},
        '{1'b0, FN_DROP_FIRST, 32'h0,        4'd0,  1'b0, '{ST_OK,    32'h0,        5'd0}},
        '{1'b0, FN_READ_AT,    32'h0,        4'd0,  1'b1, '{ST_OK,    32'h5A5A5A5A, 5'd1}},
        '{1'b0, FN_DROP_LAST,  32'h0,        4'd0,  1'b1, '{ST_OK,    32'h0,        5'd0}},
        '{1'b1, FN_APPEND,     32'd1,        4'd0,  1'b0, '{ST_OK,    32'h0,        5'd0}},
        '{1'b0, FN_APPEND,     32'hA5A5A5A5, 4'd0,  1'b1, '{ST_OK,    32'h0,        5'd1}},
        '{1'b0, FN_APPEND,     32'h0,        4'd0,  1'b1, '{ST_FULL,  32'h0,        5'd1}},
        '{1'b0, FN_PREPEND,    32'hFFFFFFFF, 4'd0,  1'b1, '{ST_FULL,  32'h0,        5'd1}},
        '{1'b1, FN_APPEND,     32'd0,        4'd0,  1'b0, '{ST_OK,    32'h0,        5'd0}},
        '{1'b0, FN_APPEND,     32'h1,        4'd0,  1'b1, '{ST_FULL,  32'h0,        5'd1}},
        '{1'b0, FN_DROP_LAST,  32'h0,        4'd0,  1'b1, '{ST_OK,    32'h0,        5'd0}},
        '{1'b1, FN_APPEND,     32'd31,       4'd0,  1'b0, '{ST_OK,    32'h0,        5'd0}},
        '{1'b0, FN_PREPEND,    32'h12345678, 4'd0,  1'b0, '{ST_OK,    32'h0,        5'd0}},
        '{1'b0, FN_CLEAR,      32'hFFFFFFFF, 4'd15, 1'b1, '{ST_OK,    32'h0,        5'd0}}
    };

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic list_resp_t step_shadow_list(input logic [2:0] fn,
                                                    input logic [WORD_BITS-1:0] word,
                                                    input logic [3:0] pos);
        list_resp_t  r;
        int unsigned lim;
        int unsigned k;
        r.status     = ST_OK;
        r.read_value = '0;
        lim = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
        case (fn)
            FN_APPEND, FN_PREPEND:
            begin
                if (shadow_len >= lim)
                begin
                    r.status = ST_FULL;
                end
                else if (fn == FN_APPEND)
                begin
                    shadow_words[shadow_len] = word;
                    shadow_len++;
                end
                else
                begin
                    for (k = shadow_len; k > 0; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[0] = word;
                    shadow_len++;
                end
            end
            FN_DROP_LAST:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else
                    shadow_len--;
            end
            FN_DROP_FIRST, FN_REMOVE_AT:
            begin
                if (fn == FN_DROP_FIRST && shadow_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (fn == FN_REMOVE_AT && pos >= shadow_len)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    for (k = (fn == FN_DROP_FIRST) ? 0 : pos; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                end
            end
            FN_READ_AT:
            begin
                if (pos >= shadow_len)
                    r.status = ST_RANGE;
                else
                    r.read_value = shadow_words[pos];
            end
            FN_CLEAR:
            begin
                shadow_len = 0;
            end
            default:
            begin
            end
        endcase
        r.length_after = shadow_len[4:0];
        return r;
    endfunction

    task automatic send_request(input logic [2:0] fn, input logic [WORD_BITS-1:0] word,
                                input logic [3:0] pos, input bit typed,
                                input list_resp_t typed_answer);
        list_resp_t predicted;
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.func          <= fn;
        req_ch.element_value <= word;
        req_ch.position      <= pos;
        do @(posedge clk); while (!req_ch.ready);
        predicted = step_shadow_list(fn, word, pos);
        pending_answers.insert(pending_answers.size(), typed ? typed_answer : predicted);
        requests_sent++;
        case (predicted.status)
            ST_FULL:  full_seen++;
            ST_EMPTY: empty_seen++;
            ST_RANGE: range_seen++;
            default:  ;
        endcase
        if (shadow_len > longest_list)
            longest_list = shadow_len;
    endtask

    task automatic write_capacity(input logic [4:0] limit);
        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= limit;
        do @(posedge clk); while (!cfg_ch.ready);
        shadow_cap = limit;
        cap_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : answer_check
        list_resp_t want;
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("Response arrived with no request outstanding.");
                    fail_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    answers_checked++;
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, rsp_ch.read_value);
                        fail_count++;
                    end
                    if (rsp_ch.length_after !== want.length_after)
                    begin
                        $error("length_after: expected %0d, got %0d",
                               want.length_after, rsp_ch.length_after);
                        fail_count++;
                    end
                end
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : rsp_ready_drive
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [2:0]           fn;
        logic [WORD_BITS-1:0] word;
        logic [3:0]           pos;
        logic [4:0]           limit;
        int                   pick;
        int                   trend_left;
        bit                   filling;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.func          = FN_APPEND;
        req_ch.element_value = '0;
        req_ch.position      = '0;
        rsp_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        no_idle              = 1'b0;
        shadow_len           = 0;
        shadow_cap           = CAP_RESET;
        trend_left           = 0;
        filling              = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_capacity(dir_rows[i].value[4:0]);
            else
                send_request(dir_rows[i].func, dir_rows[i].value, dir_rows[i].position,
                             dir_rows[i].typed, dir_rows[i].answer);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       limit = 5'd16;
                1:       limit = 5'd31;
                2:       limit = 5'($urandom_range(2, 15));
                3:       limit = 5'd1;
                4:       limit = 5'd0;
                5:       limit = 5'($urandom_range(17, 30));
                PHASES - 1: limit = 5'd16;
                default: limit = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                              : 5'($urandom_range(1, 16));
            endcase
            if (ph == PHASES - 1)
                no_idle = 1'b1;
            write_capacity(limit);
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                if (trend_left == 0)
                begin
                    filling    = !filling;
                    trend_left = $urandom_range(15, 60);
                end
                trend_left--;
                pick = $urandom_range(0, 99);
                if (pick < 1)
                    fn = FN_CLEAR;
                else if (pick < 4)
                    fn = FN_UNDEF;
                else if (pick < 20)
                    fn = FN_READ_AT;
                else if (pick < (filling ? 72 : 36))
                    fn = $urandom_range(0, 1) ? FN_APPEND : FN_PREPEND;
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       fn = FN_DROP_LAST;
                        1:       fn = FN_DROP_FIRST;
                        default: fn = FN_REMOVE_AT;
                    endcase
                end
                case ($urandom_range(0, 9))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = WORD_BITS'($urandom);
                endcase
                if (shadow_len > 0 && $urandom_range(0, 3) != 0)
                    pos = 4'($urandom_range(0, shadow_len - 1));
                else
                    pos = 4'($urandom_range(0, 15));
                send_request(fn, word, pos, 1'b0, '0);
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d requests over %0d limit settings; %0d answers checked.",
                 requests_sent, cap_writes, answers_checked);
        $display("Full: %0d, empty: %0d, out of range: %0d, longest list: %0d entries.",
                 full_seen, empty_seen, range_seen, longest_list);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
